### rtl/pps_pkg.sv
// Shared constants, opcode and command codes, and controller/datapath
// interface types for the pin pattern sequencer. No dependencies.
package pps_pkg;

    // Sizing
    localparam int PROG_DEPTH       = 32;   // program entries, 2..256
    localparam int PORT_WIDTH       = 16;   // driven pins, 1..32
    localparam int MAX_OPS_PER_TICK = 8;    // op budget per tick, 1..64

    localparam int PC_W       = $clog2(PROG_DEPTH);
    localparam bit DEPTH_POW2 = ((PROG_DEPTH & (PROG_DEPTH - 1)) == 0);
    localparam int OPS_W      = $clog2(MAX_OPS_PER_TICK + 1);

    // Field widths on the stream ports
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 5;
    localparam int OPC_W  = 3;
    localparam int VAL_W  = 32;
    localparam int PV_W   = 16;
    localparam int PCO_W  = 5;

    localparam int S_TUSER_W  = CMD_W;
    localparam int S_TDATA_W  = 40;                       // 5 + 3 + 32
    localparam int M_TDATA_W  = 24;                       // 16 + 1 + 5, padded
    localparam int M_PAD_W    = M_TDATA_W - PV_W - 1 - PCO_W;

    localparam int INSTR_W    = OPC_W + VAL_W;

    // Index reduction for a depth that is not a power of two:
    // byte fold with constant weights, then exact reciprocal multiply
    localparam int MOD_SUM_W  = 18;                       // fold sum < 2^18
    localparam int MOD_K      = MOD_SUM_W + 8;            // exact for depth <= 256
    localparam int MOD_PROD_W = MOD_SUM_W + MOD_K;
    localparam longint unsigned MOD_M =
        ((64'd1 << MOD_K) + 64'(PROG_DEPTH) - 64'd1) / 64'(PROG_DEPTH);
    localparam int MOD_C1     = (1 << 8) % PROG_DEPTH;
    localparam int MOD_C2     = (1 << 16) % PROG_DEPTH;
    localparam int MOD_C3     = (1 << 24) % PROG_DEPTH;
    localparam int MOD_STAGES = 3;
    localparam int MOD_CNT_W  = 2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_SLEEP = 3'd0;
    localparam logic [OPC_W-1:0] OP_GOTO  = 3'd1;
    localparam logic [OPC_W-1:0] OP_STOP  = 3'd2;
    localparam logic [OPC_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OPC_W-1:0] OP_SET   = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic take_in;       // capture the accepted input item
        logic mod_start;     // start index reduction
        logic mod_sel_val;   // reduce the op value (else the entry index)
        logic mem_we;        // write program entry at reduced index
        logic start_apply;   // pc from reduced index, set run, clear sleep
        logic sleep_dec;     // count down the sleep timer
        logic exec_step;     // execute sleep/clear/set/unknown op, advance pc
        logic stop;          // clear the run flag
        logic pc_from_mod;   // pc from reduced goto target
        logic out_load;      // capture status into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             run;
        logic             sleep_nz;
        logic             sleep_one;
        logic [OPC_W-1:0] op;
        logic             val_nz;
        logic             mod_done;
        logic             out_free;
    } t_dp_status;

endpackage

### rtl/pps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pps_datapath.sv
// Sequencer datapath: input capture, program RAM, pc/sleep/port/run state,
// pipelined index reducer and output register. Depends on pps_pkg, pps_ram.
module pps_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pps_pkg::t_dp_cmd           i_cmd,
    output pps_pkg::t_dp_status        o_status,
    input  logic [pps_pkg::S_TDATA_W-1:0] i_tdata,
    input  logic [pps_pkg::S_TUSER_W-1:0] i_tuser,
    input  logic                       i_m_tready,
    output logic                       o_m_tvalid,
    output logic [pps_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import pps_pkg::*;

    // Captured input item
    logic [CMD_W-1:0] r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [OPC_W-1:0] r_opc;
    logic [VAL_W-1:0] r_val;

    // Architectural state
    logic [PC_W-1:0]       r_pc,    n_pc;
    logic [VAL_W-1:0]      r_sleep, n_sleep;
    logic [PORT_WIDTH-1:0] r_port,  n_port;
    logic                  r_run,   n_run;

    // Reducer
    logic [VAL_W-1:0]      r_mod_src;
    logic [PC_W-1:0]       r_mod_acc;
    logic [MOD_CNT_W-1:0]  r_mod_cnt;
    logic [MOD_SUM_W-1:0]  r_mod_sum;
    logic [MOD_SUM_W-1:0]  r_mod_q;
    logic [MOD_SUM_W-1:0]  mod_sum;
    logic [MOD_PROD_W-1:0] mod_prod;
    logic [MOD_SUM_W-1:0]  mod_rem;
    logic [PC_W-1:0]       mod_result;

    // Output register
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic [INSTR_W-1:0] ram_rdata;
    logic [OPC_W-1:0]   ram_op;
    logic [VAL_W-1:0]   ram_val;
    logic [PC_W-1:0]    pc_inc;

    // Capture the item on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_cmd <= i_tuser;
            r_idx <= i_tdata[IDX_W-1:0];
            r_opc <= i_tdata[IDX_W +: OPC_W];
            r_val <= i_tdata[IDX_W + OPC_W +: VAL_W];
        end
    end

    // Program memory: written at the reduced index, read at pc
    pps_ram #(
        .WIDTH (INSTR_W),
        .DEPTH (PROG_DEPTH)
    ) u_prog_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we),
        .i_waddr (mod_result),
        .i_wdata ({r_opc, r_val}),
        .i_raddr (r_pc),
        .o_rdata (ram_rdata)
    );

    assign ram_op  = ram_rdata[INSTR_W-1 -: OPC_W];
    assign ram_val = ram_rdata[VAL_W-1:0];

    // Modulo by PROG_DEPTH in three stages: byte fold with weights
    // 256^i mod depth, quotient by reciprocal multiply, then remainder;
    // a power-of-two depth just takes the low bits
    assign mod_sum = MOD_SUM_W'(r_mod_src[7:0])
                   + MOD_SUM_W'(r_mod_src[15:8])  * MOD_SUM_W'(MOD_C1)
                   + MOD_SUM_W'(r_mod_src[23:16]) * MOD_SUM_W'(MOD_C2)
                   + MOD_SUM_W'(r_mod_src[31:24]) * MOD_SUM_W'(MOD_C3);
    assign mod_prod   = MOD_PROD_W'(r_mod_sum) * MOD_PROD_W'(MOD_M);
    assign mod_rem    = r_mod_sum - r_mod_q * MOD_SUM_W'(PROG_DEPTH);
    assign mod_result = DEPTH_POW2 ? r_mod_src[PC_W-1:0] : r_mod_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_cnt <= '0;
        end else if (i_cmd.mod_start) begin
            r_mod_cnt <= DEPTH_POW2 ? '0 : MOD_CNT_W'(MOD_STAGES);
        end else if (r_mod_cnt != '0) begin
            r_mod_cnt <= r_mod_cnt - 1'b1;
        end
    end

    // Source holds until the next start, so the stages settle in turn
    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_start) begin
            r_mod_src <= i_cmd.mod_sel_val ? ram_val : VAL_W'(r_idx);
        end
        r_mod_sum <= mod_sum;
        r_mod_q   <= mod_prod[MOD_K +: MOD_SUM_W];
        r_mod_acc <= mod_rem[PC_W-1:0];
    end

    // pc + 1 wrapping at the program depth
    assign pc_inc = (r_pc == PC_W'(PROG_DEPTH - 1)) ? '0 : r_pc + 1'b1;

    // Next architectural state
    always_comb begin
        n_pc    = r_pc;
        n_sleep = r_sleep;
        n_port  = r_port;
        n_run   = r_run;
        if (i_cmd.start_apply) begin
            n_pc    = mod_result;
            n_run   = 1'b1;
            n_sleep = '0;
        end
        if (i_cmd.sleep_dec) begin
            n_sleep = r_sleep - 1'b1;
        end
        if (i_cmd.exec_step) begin
            n_pc = pc_inc;
            case (ram_op)
                OP_SET:   n_port = r_port | ram_val[PORT_WIDTH-1:0];
                OP_CLEAR: n_port = r_port & ~ram_val[PORT_WIDTH-1:0];
                OP_SLEEP: begin
                    if (ram_val != '0) begin
                        n_sleep = ram_val;
                    end
                end
                default:  n_port = r_port;
            endcase
        end
        if (i_cmd.stop) begin
            n_run = 1'b0;
        end
        if (i_cmd.pc_from_mod) begin
            n_pc = mod_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= '0;
            r_sleep <= '0;
            r_port  <= '0;
            r_run   <= 1'b0;
        end else begin
            r_pc    <= n_pc;
            r_sleep <= n_sleep;
            r_port  <= n_port;
            r_run   <= n_run;
        end
    end

    // Output register: holds a result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {M_PAD_W'(0), PCO_W'(r_pc), r_run, PV_W'(r_port)};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Status to the controller
    assign o_status.cmd       = r_cmd;
    assign o_status.run       = r_run;
    assign o_status.sleep_nz  = (r_sleep != '0);
    assign o_status.sleep_one = (r_sleep == VAL_W'(1));
    assign o_status.op        = ram_op;
    assign o_status.val_nz    = (ram_val != '0);
    assign o_status.mod_done  = (r_mod_cnt == '0);
    assign o_status.out_free  = !r_out_valid || i_m_tready;

endmodule

### rtl/pps_ctrl.sv
// Sequencer controller: state machine that walks each item through load,
// start or tick execution and issues datapath commands. Depends on pps_pkg.
module pps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  pps_pkg::t_dp_status i_status,
    output pps_pkg::t_dp_cmd    o_cmd
);
    import pps_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_MOD_IDX  = 3'd2;
    localparam logic [2:0] S_EXEC_RD  = 3'd3;
    localparam logic [2:0] S_EXEC_OP  = 3'd4;
    localparam logic [2:0] S_MOD_GOTO = 3'd5;
    localparam logic [2:0] S_RESULT   = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [OPS_W-1:0] r_ops,   n_ops;

    assign o_s_tready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_ops   = r_ops;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_ops = '0;
                case (i_status.cmd)
                    CMD_LOAD, CMD_START: begin
                        o_cmd.mod_start = 1'b1;
                        n_state         = S_MOD_IDX;
                    end
                    CMD_TICK: begin
                        if (!i_status.run) begin
                            n_state = S_RESULT;
                        end else if (i_status.sleep_nz) begin
                            o_cmd.sleep_dec = 1'b1;
                            n_state = i_status.sleep_one ? S_EXEC_RD : S_RESULT;
                        end else begin
                            n_state = S_EXEC_RD;
                        end
                    end
                    default: n_state = S_RESULT;
                endcase
            end
            S_MOD_IDX: begin
                if (i_status.mod_done) begin
                    if (i_status.cmd == CMD_LOAD) begin
                        o_cmd.mem_we = 1'b1;
                    end else begin
                        o_cmd.start_apply = 1'b1;
                    end
                    n_state = S_RESULT;
                end
            end
            // RAM read of the entry at pc lands next cycle
            S_EXEC_RD: begin
                n_state = S_EXEC_OP;
            end
            S_EXEC_OP: begin
                n_ops = r_ops + 1'b1;
                case (i_status.op)
                    OP_GOTO: begin
                        o_cmd.mod_start   = 1'b1;
                        o_cmd.mod_sel_val = 1'b1;
                        n_state           = S_MOD_GOTO;
                    end
                    OP_STOP: begin
                        o_cmd.stop = 1'b1;
                        n_state    = S_RESULT;
                    end
                    default: begin
                        o_cmd.exec_step = 1'b1;
                        if ((i_status.op == OP_SLEEP && i_status.val_nz)
                            || r_ops == OPS_W'(MAX_OPS_PER_TICK - 1)) begin
                            n_state = S_RESULT;
                        end else begin
                            n_state = S_EXEC_RD;
                        end
                    end
                endcase
            end
            S_MOD_GOTO: begin
                if (i_status.mod_done) begin
                    o_cmd.pc_from_mod = 1'b1;
                    n_state = (r_ops == OPS_W'(MAX_OPS_PER_TICK)) ? S_RESULT : S_EXEC_RD;
                end
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ops   <= '0;
        end else begin
            r_state <= n_state;
            r_ops   <= n_ops;
        end
    end

endmodule

### rtl/pin_pattern_sequencer_core.sv
// Top level of the pin pattern sequencer: stream ports, controller and
// datapath. Depends on pps_pkg, pps_ctrl, pps_datapath (and pps_ram).

// Pin pattern sequencer. Each input transfer carries a command in tuser:
// load writes {op_code, op_value} to program entry entry_index, start sets
// pc to entry_index and begins running, tick runs the stored program for
// one time step (up to MAX_OPS_PER_TICK ops). Every item returns exactly
// one result with the pin levels, the run flag and the next pc. One item
// is handled at a time; the finished result sits in an output register so
// the next item can be accepted while it waits. Every op waits for the
// registered read of the program RAM, which has one write and one read
// port. With a depth that is not a power of two, each entry index or GOTO
// target is reduced by a three-stage fold and reciprocal-multiply unit.
// The program RAM has no reset: run only entries that were loaded.
module pin_pattern_sequencer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: entry_index[4:0], op_code[7:5], op_value[39:8]
    input  logic [pps_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [pps_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // Output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: port_value[15:0], running[16], program_counter[21:17], zero[23:22]
    output logic [pps_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import pps_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    pps_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

### rtl/pps_checker.sv
// Port-level assertions for the pin pattern sequencer and the bind that
// attaches them to the top level. Depends on pps_pkg.
module pps_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [pps_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic [pps_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [pps_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import pps_pkg::*;

    // A stalled result holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No result right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // One item at a time: the input closes after each transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // Pad bits of a result are zero
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1 -: M_PAD_W] == '0)
        else $error("result pad bits not zero");

endmodule

bind pin_pattern_sequencer_core pps_checker u_pps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### test/tb_pin_pattern_sequencer_core.sv
// Self-checking testbench for pin_pattern_sequencer_core: directed and random
// command streams, a local predictor of port, run flag and pc, and random stalls.
// Depends on pps_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module tb_pin_pattern_sequencer_core;
    import pps_pkg::*;

    // Codes outside the defined sets
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;
    localparam logic [OPC_W-1:0] OP_RSVD_LO = 3'd5;
    localparam logic [OPC_W-1:0] OP_RSVD_HI = 3'd7;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RANDOM_ITEMS   = 600;

    typedef struct packed {
        logic [PV_W-1:0]  port_value;
        logic             running;
        logic [PCO_W-1:0] program_counter;
    } t_pin_status;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Predictor state
    logic [OPC_W-1:0]      pgm_op  [PROG_DEPTH];
    logic [VAL_W-1:0]      pgm_val [PROG_DEPTH];
    logic [PC_W-1:0]       seq_pc;
    logic [VAL_W-1:0]      seq_sleep;
    logic [PORT_WIDTH-1:0] seq_port;
    logic                  seq_run;

    t_pin_status expected_status_q[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    bit          idle_en = 1'b1;
    int          hold_req = 0;
    int          hold_ack = 0;

    pin_pattern_sequencer_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // One tick of the stored program
    function automatic void run_program_tick();
        int               ops;
        bit               halted;
        logic [PC_W-1:0]  at;
        logic [OPC_W-1:0] op;
        logic [VAL_W-1:0] v;
        if (!seq_run) return;
        if (seq_sleep != 0) begin
            seq_sleep = seq_sleep - 1;
            if (seq_sleep != 0) return;
        end
        ops = 0;
        halted = 1'b0;
        while (seq_run && ops < MAX_OPS_PER_TICK && !halted) begin
            at = seq_pc;
            op = pgm_op[at];
            v  = pgm_val[at];
            ops++;
            if (op == OP_GOTO) begin
                seq_pc = PC_W'(v % PROG_DEPTH);
            end else if (op == OP_STOP) begin
                seq_run = 1'b0;
            end else begin
                if (op == OP_CLEAR)
                    seq_port = seq_port & ~v[PORT_WIDTH-1:0];
                else if (op == OP_SET)
                    seq_port = seq_port | v[PORT_WIDTH-1:0];
                seq_pc = PC_W'((at + 1) % PROG_DEPTH);
                if (op == OP_SLEEP && v != 0) begin
                    seq_sleep = v;
                    halted = 1'b1;
                end
            end
        end
    endfunction

    // Status after one accepted command
    function automatic t_pin_status predict_pin_status(logic [CMD_W-1:0] cmd,
            logic [IDX_W-1:0] idx, logic [OPC_W-1:0] opc, logic [VAL_W-1:0] val);
        t_pin_status st;
        case (cmd)
            CMD_LOAD: begin
                pgm_op[PC_W'(idx % PROG_DEPTH)]  = opc;
                pgm_val[PC_W'(idx % PROG_DEPTH)] = val;
            end
            CMD_START: begin
                seq_pc    = PC_W'(idx % PROG_DEPTH);
                seq_run   = 1'b1;
                seq_sleep = '0;
            end
            CMD_TICK: run_program_tick();
            default: ;
        endcase
        st.port_value      = PV_W'(seq_port);
        st.running         = seq_run;
        st.program_counter = PCO_W'(seq_pc);
        return st;
    endfunction

    // Offer one command, optionally after an idle burst, and wait for its transfer
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
            logic [OPC_W-1:0] opc, logic [VAL_W-1:0] val);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {val, opc, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_status_q.push_back(predict_pin_status(cmd, idx, opc, val));
        items_sent++;
    endtask

    task automatic send_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random opcode and value, biased toward short sleeps
    function automatic void pick_op(output logic [OPC_W-1:0] opc,
            output logic [VAL_W-1:0] val);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)      opc = OP_SET;
        else if (r < 45) opc = OP_CLEAR;
        else if (r < 65) opc = OP_SLEEP;
        else if (r < 80) opc = OP_GOTO;
        else if (r < 90) opc = OP_STOP;
        else             opc = OPC_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        val = $urandom;
        if (opc == OP_SLEEP) begin
            r = $urandom_range(0, 9);
            if (r < 3)       val = '0;
            else if (r < 8)  val = $urandom_range(1, 4);
            else if (r == 8) val = $urandom_range(5, 40);
        end
    endfunction

    // Every entry becomes STOP so no tick can reach an unloaded entry
    task automatic test_program_init();
        send_item(CMD_TICK, '0, OP_SLEEP, '0);
        send_item(CMD_NONE, '1, OP_RSVD_HI, '1);
        for (int i = 0; i < PROG_DEPTH; i++)
            send_item(CMD_LOAD, IDX_W'(i), OP_STOP, (i % 2) ? '1 : '0);
        send_item(CMD_TICK, '1, OP_SET, '1);
    endtask

    // Each op, sleep of zero, op budget, restarts, wrap of pc and index
    task automatic test_directed_ops();
        send_item(CMD_LOAD, 5'd0, OP_SET, 32'hFFFF_FFFF);
        send_item(CMD_LOAD, 5'd1, OP_CLEAR, 32'h0000_F00F);
        send_item(CMD_LOAD, 5'd2, OP_SLEEP, 32'd0);
        send_item(CMD_LOAD, 5'd3, OP_RSVD_HI, 32'h0000_1234);
        send_item(CMD_LOAD, 5'd4, OP_SLEEP, 32'd2);
        send_item(CMD_LOAD, 5'd5, OP_GOTO, 32'hFFFF_FFE7);
        send_item(CMD_LOAD, 5'd7, OP_CLEAR, 32'hFFFF_FFFF);
        send_item(CMD_LOAD, 5'd8, OP_STOP, 32'd0);
        send_item(CMD_START, 5'd0, OP_SLEEP, '0);
        repeat (4) send_item(CMD_TICK, '0, OP_SLEEP, '0);
        // GOTO onto itself: only the op budget ends the tick
        send_item(CMD_LOAD, 5'd9, OP_GOTO, 32'd9);
        send_item(CMD_START, 5'd9, OP_SLEEP, '0);
        repeat (2) send_item(CMD_TICK, '0, OP_SLEEP, '0);
        // restart while running, load while running, unknown command
        send_item(CMD_START, 5'd0, OP_SLEEP, '0);
        send_item(CMD_TICK, '0, OP_SLEEP, '0);
        send_item(CMD_LOAD, 5'd7, OP_SET, 32'h0000_8001);
        send_item(CMD_NONE, 5'd3, OP_SET, 32'hA5A5_A5A5);
        // start while asleep clears the sleep count
        send_item(CMD_START, 5'd5, OP_SLEEP, '0);
        send_item(CMD_TICK, '0, OP_SLEEP, '0);
        // pc wraps from the last entry to the first
        send_item(CMD_LOAD, 5'd31, OP_SET, 32'h0001_0002);
        send_item(CMD_START, 5'd31, OP_SLEEP, '0);
        send_item(CMD_TICK, '0, OP_SLEEP, '0);
    endtask

    // Mostly load/start/tick sequences, some noise
    task automatic test_random_programs(int n_items);
        int               stop_at;
        logic [OPC_W-1:0] opc;
        logic [VAL_W-1:0] val;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 4) != 0) begin
                repeat ($urandom_range(1, 8)) begin
                    pick_op(opc, val);
                    send_item(CMD_LOAD, IDX_W'($urandom), opc, val);
                end
                send_item(CMD_START, IDX_W'($urandom), OPC_W'($urandom), $urandom);
                repeat ($urandom_range(4, 16)) begin
                    if ($urandom_range(0, 9) == 0) begin
                        pick_op(opc, val);
                        send_item(CMD_LOAD, IDX_W'($urandom), opc, val);
                    end
                    send_item(CMD_TICK, IDX_W'($urandom), OPC_W'($urandom), $urandom);
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(CMD_W'($urandom), IDX_W'($urandom), OPC_W'($urandom),
                              $urandom);
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        bit saved_idle;
        saved_idle = idle_en;
        idle_en = 1'b0;
        send_item(CMD_START, IDX_W'($urandom), OP_SLEEP, '0);
        hold_req++;
        repeat (12)
            send_item(($urandom_range(0, 1) != 0) ? CMD_TICK : CMD_LOAD,
                      IDX_W'($urandom), OP_SET, $urandom);
        idle_en = saved_idle;
    endtask

    // Back-to-back traffic, no stalls on either side
    task automatic test_no_idle();
        idle_en = 1'b0;
        test_random_programs(60);
    endtask

    // Receiver: random stall bursts, plus a long hold-off on request
    initial begin : rx_driver
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_ack) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_ack = hold_req;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Check each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_pin_status exp_st;
        t_pin_status got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.port_value      = m_axis_tdata[PV_W-1:0];
            got.running         = m_axis_tdata[PV_W];
            got.program_counter = m_axis_tdata[PV_W+1 +: PCO_W];
            if (expected_status_q.size() == 0) begin
                $error("unexpected result transfer: tdata %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                exp_st = expected_status_q.pop_front();
                if (got.port_value !== exp_st.port_value) begin
                    $error("port_value: expected %h, actual %h",
                           exp_st.port_value, got.port_value);
                    mismatch_count++;
                end
                if (got.running !== exp_st.running) begin
                    $error("running: expected %b, actual %b", exp_st.running, got.running);
                    mismatch_count++;
                end
                if (got.program_counter !== exp_st.program_counter) begin
                    $error("program_counter: expected %0d, actual %0d",
                           exp_st.program_counter, got.program_counter);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        int quiet_cycles;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        for (int i = 0; i < PROG_DEPTH; i++) begin
            pgm_op[i]  = OP_STOP;
            pgm_val[i] = '0;
        end
        seq_pc    = '0;
        seq_sleep = '0;
        seq_port  = '0;
        seq_run   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_program_init();
        test_directed_ops();
        test_random_programs(RANDOM_ITEMS / 2);
        test_backpressure();
        test_random_programs(RANDOM_ITEMS / 2);
        test_no_idle();

        send_idle();
        while (expected_status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_status_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
